[rtl/cdt_pkg.sv]
package cdt_pkg;

  // Command codes carried in the low bits of the input word
  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_PAUSE = 3'd2,
    CMD_SET   = 3'd3,
    CMD_STEP  = 3'd4
  } cmd_e;

  // LED pattern codes
  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_RUN  = 2'd1,
    LED_STOP = 2'd2
  } led_e;

  localparam int unsigned SecW  = 8;
  localparam int unsigned HundW = 7;

  localparam logic [SecW-1:0]  SecReset = 8'd10;
  localparam logic [SecW-1:0]  SecMax   = 8'd255;
  localparam logic [HundW-1:0] HundTop  = 7'd99;

  // Timer status after one command, before the digit split
  typedef struct packed {
    logic             running;
    logic             expired;
    led_e             led;
    logic [SecW-1:0]  seconds;
    logic [HundW-1:0] hundredths;
  } status_t;

  // Decimal display digits
  typedef struct packed {
    logic [1:0] sec_hundreds;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
    logic [3:0] centi_tens;
    logic [3:0] centi_ones;
  } digits_t;

endpackage

[rtl/cdt_digits.sv]
module cdt_digits (
  input  cdt_pkg::status_t status_i,
  output cdt_pkg::digits_t digits_o
);
  import cdt_pkg::*;

  logic [6:0]  sec_rem;
  logic [1:0]  sec_hund;
  logic [14:0] sec_prod;
  logic [14:0] cen_prod;
  logic [3:0]  sec_tens;
  logic [3:0]  cen_tens;
  logic [7:0]  sec_tens_x10;
  logic [7:0]  cen_tens_x10;

  // Strip the hundreds of the seconds by compare and subtract
  always_comb begin
    if (status_i.seconds >= 8'd200) begin
      sec_hund = 2'd2;
      sec_rem  = 7'(status_i.seconds - 8'd200);
    end else if (status_i.seconds >= 8'd100) begin
      sec_hund = 2'd1;
      sec_rem  = 7'(status_i.seconds - 8'd100);
    end else begin
      sec_hund = 2'd0;
      sec_rem  = status_i.seconds[6:0];
    end
  end

  // Divide by ten through a reciprocal multiply, exact below 100
  assign sec_prod     = 15'(sec_rem) * 15'd205;
  assign cen_prod     = 15'(status_i.hundredths) * 15'd205;
  assign sec_tens     = sec_prod[14:11];
  assign cen_tens     = cen_prod[14:11];
  assign sec_tens_x10 = {1'b0, sec_tens, 3'b000} + {3'b000, sec_tens, 1'b0};
  assign cen_tens_x10 = {1'b0, cen_tens, 3'b000} + {3'b000, cen_tens, 1'b0};

  assign digits_o.sec_hundreds = sec_hund;
  assign digits_o.sec_tens     = sec_tens;
  assign digits_o.sec_ones     = 4'({1'b0, sec_rem} - sec_tens_x10);
  assign digits_o.centi_tens   = cen_tens;
  assign digits_o.centi_ones   = 4'({1'b0, status_i.hundredths} - cen_tens_x10);

endmodule

[rtl/countdown_timer_with_digits.sv]
// Countdown timer with decimal display digits.
// Pipeline: an accepted input word is registered in the status stage (st_valid_q), then in the
// output stage (out_valid_q), which drives m_axis_tvalid.
// Throughput: one command per cycle; the state update and the digit split each take one
// register stage, and the first stage stalls only while the output stage holds a word
// and m_axis_tready is low.
// Reset: asynchronous, active low; seconds 10, hundredths 0, timer stopped.
module countdown_timer_with_digits (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] cmd, [11:3] operand_value, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] running, [1] expired, [3:2] led_code, [11:4] seconds_left,
  // [18:12] hundredths_left, [20:19] sec_hundreds_digit, [24:21] sec_tens_digit,
  // [28:25] sec_ones_digit, [32:29] centi_tens_digit, [36:33] centi_ones_digit,
  // [39:37] zero
  output logic [39:0] m_axis_tdata
);
  import cdt_pkg::*;

  logic [SecW-1:0]  sec_q, sec_d;
  logic [HundW-1:0] hund_q, hund_d;
  logic             run_q, run_d;

  logic       st_valid_q;
  status_t    st_q, st_d;
  logic       out_valid_q;
  status_t    out_st_q;
  digits_t    out_dig_q;
  digits_t    dig;

  logic       out_load_ok;
  logic       in_accept;
  cmd_e       cmd;
  logic signed [8:0] opnd;
  logic       opnd_neg;
  logic       opnd_pos;

  assign cmd      = cmd_e'(s_axis_tdata[2:0]);
  assign opnd     = s_axis_tdata[11:3];
  assign opnd_neg = opnd[8];
  assign opnd_pos = !opnd[8] && (opnd != 9'sd0);

  // Handshake: each stage loads when it is empty or the stage after it takes its word
  assign out_load_ok   = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !st_valid_q || out_load_ok;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Apply one command to the timer state
  always_comb begin
    sec_d  = sec_q;
    hund_d = hund_q;
    run_d  = run_q;
    st_d.expired = 1'b0;
    st_d.led     = LED_NONE;
    case (cmd)
      CMD_TICK: begin
        if (run_q) begin
          if (hund_q != '0) begin
            hund_d = hund_q - 7'd1;
          end else if (sec_q != '0) begin
            sec_d  = sec_q - 8'd1;
            hund_d = HundTop;
          end else begin
            run_d        = 1'b0;
            st_d.expired = 1'b1;
            st_d.led     = LED_STOP;
          end
        end
      end
      CMD_START: begin
        run_d    = 1'b1;
        st_d.led = LED_RUN;
      end
      CMD_PAUSE: begin
        run_d    = 1'b0;
        st_d.led = LED_STOP;
      end
      CMD_SET: begin
        sec_d = opnd[7:0];
      end
      CMD_STEP: begin
        run_d  = 1'b0;
        hund_d = '0;
        if (opnd_pos && sec_q != SecMax) begin
          sec_d = sec_q + 8'd1;
        end else if (opnd_neg && sec_q != '0) begin
          sec_d = sec_q - 8'd1;
        end
      end
      default: begin
      end
    endcase
    st_d.running    = run_d;
    st_d.seconds    = sec_d;
    st_d.hundredths = hund_d;
  end

  // Hold the timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= SecReset;
      hund_q <= '0;
      run_q  <= 1'b0;
    end else if (in_accept) begin
      sec_q  <= sec_d;
      hund_q <= hund_d;
      run_q  <= run_d;
    end
  end

  // Status stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      st_valid_q <= s_axis_tvalid;
    end
  end

  // Status stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      st_q <= st_d;
    end
  end

  cdt_digits u_digits (
    .status_i (st_q),
    .digits_o (dig)
  );

  // Output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_q <= st_valid_q;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (out_load_ok && st_valid_q) begin
      out_st_q  <= st_q;
      out_dig_q <= dig;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_dig_q.centi_ones,
                          out_dig_q.centi_tens,
                          out_dig_q.sec_ones,
                          out_dig_q.sec_tens,
                          out_dig_q.sec_hundreds,
                          out_st_q.hundredths,
                          out_st_q.seconds,
                          out_st_q.led,
                          out_st_q.expired,
                          out_st_q.running};

endmodule
